// ===== rtl/core/ahsm_pkg.sv =====
// Shared types and constants for the audio-to-haptic slew mapper.
package ahsm_pkg;

  // Field widths
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned ELAPSED_W  = 24;
  localparam int unsigned DIVISOR_W  = 26;  // fade_time_ms * 1000 < 2^26
  localparam int unsigned STEP_BITS  = 15;  // quotient bits below full scale
  localparam int unsigned TARGET_W   = 21;  // widest sum of gain terms
  localparam int unsigned CFG_IDX_W  = 3;

  // Fixed-point constants (Q1.15 levels, Q0.16 peak fraction)
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'd32768;
  localparam logic [LEVEL_W-1:0] DEAD_ZONE  = 16'd4915;
  localparam logic [GAIN_W-1:0]  PEAK_FRAC  = 16'd19661;
  localparam logic [GAIN_W-1:0]  MS_TO_US   = 16'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASS_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TREBLE_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_TIME_MS = 3'd5;

  // Reset values of the configuration registers
  localparam logic [3:0]        RST_ENABLE_MASK = 4'hF;
  localparam logic [GAIN_W-1:0] RST_GAIN        = 16'd4096;
  localparam logic [GAIN_W-1:0] RST_FADE_MS     = 16'd100;

  // Enable mask bits
  localparam int unsigned EN_RUMBLE  = 0;
  localparam int unsigned EN_LOW     = 1;
  localparam int unsigned EN_HIGH    = 2;
  localparam int unsigned EN_TRIGGER = 3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SLEW
  } state_t;

endpackage

// ===== rtl/core/ahsm_divider.sv =====
// Bit-serial divider for the slew step: floor(dividend * 2^15 / divisor), saturated.
module ahsm_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ahsm_pkg::ELAPSED_W-1:0]    dividend,
  input  logic [ahsm_pkg::DIVISOR_W-1:0]    divisor,
  output logic                              done,
  output logic [ahsm_pkg::LEVEL_W-1:0]      quotient
);

  logic                              busy;
  logic [3:0]                        count;
  logic [ahsm_pkg::DIVISOR_W-1:0]    rem;
  logic [ahsm_pkg::STEP_BITS-1:0]    q;

  logic [ahsm_pkg::DIVISOR_W:0]      rem_shift;
  logic                              q_bit;
  logic [ahsm_pkg::DIVISOR_W-1:0]    rem_next;

  // One restoring step: shift, trial subtract
  always_comb begin
    rem_shift = {rem, 1'b0};
    q_bit     = rem_shift >= {1'b0, divisor};
    rem_next  = q_bit ? (rem_shift[ahsm_pkg::DIVISOR_W-1:0] - divisor)
                      : rem_shift[ahsm_pkg::DIVISOR_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if ({{(ahsm_pkg::DIVISOR_W-ahsm_pkg::ELAPSED_W){1'b0}}, dividend} >= divisor) begin
          // quotient would reach full scale or beyond
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && count == 4'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {{(ahsm_pkg::DIVISOR_W-ahsm_pkg::ELAPSED_W){1'b0}}, dividend};
      q        <= '0;
      count    <= 4'(ahsm_pkg::STEP_BITS);
      quotient <= ahsm_pkg::FULL_SCALE;
    end else if (busy) begin
      rem   <= rem_next;
      q     <= {q[ahsm_pkg::STEP_BITS-2:0], q_bit};
      count <= count - 4'd1;
      if (count == 4'd1) begin
        quotient <= {1'b0, q[ahsm_pkg::STEP_BITS-2:0], q_bit};
      end
    end
  end

endmodule

// ===== rtl/core/audio_to_haptic_slew_mapper.sv =====
// Top level of the audio-to-haptic slew mapper.
//
// Takes one audio feature frame per transfer and returns one set of four
// motor drives. The five gain products and the fade divisor go one after
// another through a single shared 16x16 multiplier, then the slew step
// elapsed_us*32768/(fade_time_ms*1000) comes from a bit-serial divider at
// one quotient bit per cycle. The divider is skipped when fade_time_ms is
// zero, and it gives full scale without the serial run when the step
// saturates. The input side is not ready while a frame is in work, and a
// result waits in the output register until taken. The user must write
// configuration only while the block is idle; the block itself does not
// enforce this.
module audio_to_haptic_slew_mapper (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // input frames
  input  logic         s_tvalid,
  output logic         s_tready,
  // bass_level, treble_level, volume_level, dynamic_level, peak_level, elapsed_us
  input  logic [103:0] s_tdata,
  // motor drives
  output logic         m_tvalid,
  input  logic         m_tready,
  // low_motor_drive, high_motor_drive, left_trigger_drive, right_trigger_drive
  output logic [63:0]  m_tdata
);

  // Multiplier operand slots
  localparam logic [2:0] MUL_FADE    = 3'd0;
  localparam logic [2:0] MUL_BASS    = 3'd1;
  localparam logic [2:0] MUL_TREBLE  = 3'd2;
  localparam logic [2:0] MUL_VOLUME  = 3'd3;
  localparam logic [2:0] MUL_DYNAMIC = 3'd4;
  localparam logic [2:0] MUL_PEAK    = 3'd5;
  localparam logic [2:0] MUL_DRAIN   = 3'd6;

  // Configuration registers
  logic [3:0]  enable_mask;
  logic [15:0] bass_gain;
  logic [15:0] treble_gain;
  logic [15:0] volume_gain;
  logic [15:0] dynamic_gain;
  logic [15:0] fade_time_ms;

  // Captured frame
  logic [15:0] bass_in;
  logic [15:0] treble_in;
  logic [15:0] volume_in;
  logic [15:0] dynamic_in;
  logic [15:0] peak_in;
  logic [23:0] elapsed_in;

  // Sequencer and datapath
  ahsm_pkg::state_t state, state_next;
  logic [2:0]  mul_idx;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] prod;
  logic [ahsm_pkg::DIVISOR_W-1:0] divisor;
  logic [ahsm_pkg::TARGET_W-1:0]  tgt_low;
  logic [ahsm_pkg::TARGET_W-1:0]  tgt_high;
  logic [ahsm_pkg::TARGET_W-1:0]  tgt_trig;
  logic [15:0] step;

  // Kept levels
  logic [15:0] low_level;
  logic [15:0] high_level;
  logic [15:0] ltrig_level;
  logic [15:0] rtrig_level;

  logic        in_xfer;
  logic        div_start;
  logic        div_done;
  logic [15:0] div_quotient;
  logic        slew_go;
  logic        immediate;
  logic [15:0] step_now;
  logic [15:0] low_next;
  logic [15:0] high_next;
  logic [15:0] ltrig_next;
  logic [15:0] rtrig_next;

  function automatic logic [15:0] clamp_full(input logic [ahsm_pkg::TARGET_W-1:0] v);
    logic [15:0] r;
    if (v > ahsm_pkg::TARGET_W'(ahsm_pkg::FULL_SCALE)) r = ahsm_pkg::FULL_SCALE;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [15:0] slew(input logic [15:0] cur, input logic [15:0] tgt,
                                       input logic [15:0] stp, input logic jump);
    logic [15:0] diff;
    logic [15:0] r;
    diff = (tgt >= cur) ? (tgt - cur) : (cur - tgt);
    if (jump || diff <= stp) r = tgt;
    else if (tgt > cur) r = cur + stp;
    else r = cur - stp;
    return r;
  endfunction

  function automatic logic [15:0] dead_zone(input logic [15:0] lvl);
    return (lvl <= ahsm_pkg::DEAD_ZONE) ? 16'd0 : lvl;
  endfunction

  assign in_xfer   = s_tvalid && s_tready;
  assign immediate = (fade_time_ms == 16'd0);

  // Step divider
  ahsm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed_in),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask  <= ahsm_pkg::RST_ENABLE_MASK;
      bass_gain    <= ahsm_pkg::RST_GAIN;
      treble_gain  <= ahsm_pkg::RST_GAIN;
      volume_gain  <= ahsm_pkg::RST_GAIN;
      dynamic_gain <= ahsm_pkg::RST_GAIN;
      fade_time_ms <= ahsm_pkg::RST_FADE_MS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ahsm_pkg::REG_ENABLE_MASK:  enable_mask  <= cfg_data[3:0];
        ahsm_pkg::REG_BASS_GAIN:    bass_gain    <= cfg_data;
        ahsm_pkg::REG_TREBLE_GAIN:  treble_gain  <= cfg_data;
        ahsm_pkg::REG_VOLUME_GAIN:  volume_gain  <= cfg_data;
        ahsm_pkg::REG_DYNAMIC_GAIN: dynamic_gain <= cfg_data;
        ahsm_pkg::REG_FADE_TIME_MS: fade_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    case (mul_idx)
      MUL_FADE:    begin mul_a = fade_time_ms; mul_b = ahsm_pkg::MS_TO_US; end
      MUL_BASS:    begin mul_a = bass_in;      mul_b = bass_gain;          end
      MUL_TREBLE:  begin mul_a = treble_in;    mul_b = treble_gain;        end
      MUL_VOLUME:  begin mul_a = volume_in;    mul_b = volume_gain;        end
      MUL_DYNAMIC: begin mul_a = dynamic_in;   mul_b = dynamic_gain;       end
      MUL_PEAK:    begin mul_a = peak_in;      mul_b = ahsm_pkg::PEAK_FRAC; end
      default:     begin mul_a = '0;           mul_b = '0;                 end
    endcase
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    slew_go    = 1'b0;
    step_now   = step;
    case (state)
      ahsm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ahsm_pkg::ST_MUL;
      end
      ahsm_pkg::ST_MUL: begin
        if (mul_idx == MUL_DRAIN) begin
          if (immediate) begin
            state_next = ahsm_pkg::ST_SLEW;
          end else begin
            div_start  = 1'b1;
            state_next = ahsm_pkg::ST_DIV;
          end
        end
      end
      ahsm_pkg::ST_DIV: begin
        if (div_done) state_next = ahsm_pkg::ST_SLEW;
      end
      ahsm_pkg::ST_SLEW: begin
        if (!m_tvalid || m_tready) begin
          slew_go    = 1'b1;
          state_next = ahsm_pkg::ST_IDLE;
        end
      end
      default: state_next = ahsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ahsm_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Frame capture, multiply and accumulate
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bass_in    <= s_tdata[15:0];
      treble_in  <= s_tdata[31:16];
      volume_in  <= s_tdata[47:32];
      dynamic_in <= s_tdata[63:48];
      peak_in    <= s_tdata[79:64];
      elapsed_in <= s_tdata[103:80];
      mul_idx    <= MUL_FADE;
      tgt_low    <= '0;
      tgt_high   <= '0;
      tgt_trig   <= '0;
    end else if (state == ahsm_pkg::ST_MUL) begin
      prod    <= mul_a * mul_b;
      mul_idx <= mul_idx + 3'd1;
      // accumulate the product from the previous slot
      case (mul_idx)
        MUL_BASS: divisor <= prod[ahsm_pkg::DIVISOR_W-1:0];
        MUL_TREBLE: begin
          if (enable_mask[ahsm_pkg::EN_RUMBLE] && enable_mask[ahsm_pkg::EN_LOW])
            tgt_low <= tgt_low + {1'b0, prod[31:12]};
        end
        MUL_VOLUME: begin
          if (enable_mask[ahsm_pkg::EN_RUMBLE] && enable_mask[ahsm_pkg::EN_HIGH])
            tgt_high <= tgt_high + {1'b0, prod[31:12]};
        end
        MUL_DYNAMIC: begin
          if (enable_mask[ahsm_pkg::EN_RUMBLE]) begin
            tgt_low  <= tgt_low  + {2'b00, prod[31:13]};
            tgt_high <= tgt_high + {2'b00, prod[31:13]};
          end
        end
        MUL_PEAK: begin
          if (enable_mask[ahsm_pkg::EN_TRIGGER])
            tgt_trig <= tgt_trig + {1'b0, prod[31:12]};
        end
        MUL_DRAIN: begin
          if (enable_mask[ahsm_pkg::EN_TRIGGER])
            tgt_trig <= tgt_trig + {5'd0, prod[31:16]};
        end
        default: ;
      endcase
    end
    if (div_done) step <= div_quotient;
  end

  // Slew of the four levels toward their targets
  always_comb begin
    low_next   = slew(low_level,   clamp_full(tgt_low),  step_now, immediate);
    high_next  = slew(high_level,  clamp_full(tgt_high), step_now, immediate);
    ltrig_next = slew(ltrig_level, clamp_full(tgt_trig), step_now, immediate);
    rtrig_next = slew(rtrig_level, clamp_full(tgt_trig), step_now, immediate);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level   <= '0;
      high_level  <= '0;
      ltrig_level <= '0;
      rtrig_level <= '0;
    end else if (slew_go) begin
      low_level   <= low_next;
      high_level  <= high_next;
      ltrig_level <= ltrig_next;
      rtrig_level <= rtrig_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (slew_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slew_go) begin
      m_tdata <= {dead_zone(rtrig_next), dead_zone(ltrig_next),
                  dead_zone(high_next), dead_zone(low_next)};
    end
  end

endmodule
